// File: sv/rwhp_pkg.sv
`default_nettype none

package rwhp_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Offsets of the last byte of each tag in the file signature.
    localparam int unsigned RIFF_LAST = 3;
    localparam int unsigned SIG_LAST  = 11;
    localparam int unsigned HDR_LEN   = 8;
    localparam int unsigned FMT_LEN   = 16;

    typedef enum logic [3:0] {
        PH_SIG  = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DEAD = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_TAGS  = 3'd2,
        ST_NO_FORMAT = 3'd3,
        ST_NO_DATA   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_align;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
    } result_t;

endpackage

`default_nettype wire

// File: sv/rwhp_if.sv
`default_nettype none

interface rwhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       is_last;

    modport source (output valid, output file_byte, output is_last, input ready);
    modport sink (input valid, input file_byte, input is_last, output ready);
endinterface

interface rwhp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;

    modport source (
        output valid, output status, output format_tag, output channel_count,
        output sample_rate, output byte_rate, output frame_align, output sample_bits,
        output payload_offset, output payload_length, input ready
    );
    modport sink (
        input valid, input status, input format_tag, input channel_count,
        input sample_rate, input byte_rate, input frame_align, input sample_bits,
        input payload_offset, input payload_length, output ready
    );
endinterface

`default_nettype wire

// File: sv/riff_wave_header_parser_core.sv
// RIFF/WAVE header parser. The block takes a file one byte per transaction on
// the stream channel, from offset zero, with is_last set on the final byte, and
// accepts one byte in every cycle unless held off: each byte only advances
// counters and shift registers. It checks the RIFF and WAVE tags, walks the
// chunks that follow (8-byte header, 32-bit little-endian size, no pad byte),
// and keeps the last complete fmt chunk of at least 16 bytes and the last
// complete data chunk. The final byte produces one report transaction in the
// following cycle from a result register; the parser then starts afresh on the
// next byte. The stream is held off in any cycle in which a report is waiting
// and report.ready is low. The byte position saturates at 2^POSITION_BITS - 1.
`default_nettype none

module riff_wave_header_parser_core #(
    parameter int unsigned POSITION_BITS = rwhp_pkg::POSITION_BITS_DEFAULT
) (
    input  wire             clk,
    input  wire             rst_n,
    rwhp_byte_if.sink       stream,
    rwhp_result_if.source   report
);

    localparam int unsigned EXT_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    rwhp_pkg::phase_t         phase_reg, phase_next;
    logic                     tags_ok_reg, tags_ok_next;
    logic [31:0]              sig_reg, sig_next;
    logic [63:0]              hdr_reg, hdr_next;
    logic [2:0]               hdr_count_reg, hdr_count_next;
    logic [31:0]              remaining_reg, remaining_next;
    logic [4:0]               body_idx_reg, body_idx_next;
    rwhp_pkg::kind_t          kind_reg, kind_next;
    logic [127:0]             pending_fmt_reg, pending_fmt_next;
    logic [127:0]             fmt_reg, fmt_next;
    logic                     fmt_found_reg, fmt_found_next;
    logic [63:0]              pending_span_reg, pending_span_next;
    logic [63:0]              span_reg, span_next;
    logic                     data_found_reg, data_found_next;

    logic                     res_valid_reg, res_valid_next;
    rwhp_pkg::result_t        res_reg, res_next;

    logic                     accept;
    logic                     finish;
    logic [EXT_BITS-1:0]      pos_inc;
    logic [31:0]              chunk_size;
    logic [31:0]              chunk_id;

    assign accept       = stream.valid && stream.ready;
    assign stream.ready = !res_valid_reg || report.ready;
    assign pos_inc      = EXT_BITS'(pos_reg) + EXT_BITS'(1);
    assign hdr_next     = (accept && phase_reg == rwhp_pkg::PH_HDR)
                          ? {stream.file_byte, hdr_reg[63:8]} : hdr_reg;
    assign chunk_size   = hdr_next[63:32];
    assign chunk_id     = hdr_next[31:0];

    always_comb
    begin
        pos_next          = pos_reg;
        phase_next        = phase_reg;
        tags_ok_next      = tags_ok_reg;
        sig_next          = sig_reg;
        hdr_count_next    = hdr_count_reg;
        remaining_next    = remaining_reg;
        body_idx_next     = body_idx_reg;
        kind_next         = kind_reg;
        pending_fmt_next  = pending_fmt_reg;
        fmt_next          = fmt_reg;
        fmt_found_next    = fmt_found_reg;
        pending_span_next = pending_span_reg;
        span_next         = span_reg;
        data_found_next   = data_found_reg;
        finish            = 1'b0;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && !report.ready;

        if (accept)
        begin
            case (phase_reg)
                rwhp_pkg::PH_SIG:
                begin
                    sig_next = {stream.file_byte, sig_reg[31:8]};
                    if (pos_reg == POSITION_BITS'(rwhp_pkg::RIFF_LAST)
                        && sig_next != rwhp_pkg::TAG_RIFF)
                    begin
                        tags_ok_next = 1'b0;
                    end
                    if (pos_reg == POSITION_BITS'(rwhp_pkg::SIG_LAST))
                    begin
                        if (sig_next != rwhp_pkg::TAG_WAVE)
                        begin
                            tags_ok_next = 1'b0;
                        end
                        phase_next     = tags_ok_next ? rwhp_pkg::PH_HDR : rwhp_pkg::PH_DEAD;
                        hdr_count_next = '0;
                    end
                end
                rwhp_pkg::PH_HDR:
                begin
                    hdr_count_next = hdr_count_reg + 3'd1;
                    if (hdr_count_reg == 3'(rwhp_pkg::HDR_LEN - 1))
                    begin
                        kind_next = rwhp_pkg::KIND_OTHER;
                        if (chunk_id == rwhp_pkg::TAG_FMT
                            && chunk_size >= 32'(rwhp_pkg::FMT_LEN))
                        begin
                            kind_next = rwhp_pkg::KIND_FMT;
                        end
                        else if (chunk_id == rwhp_pkg::TAG_DATA)
                        begin
                            kind_next         = rwhp_pkg::KIND_DATA;
                            pending_span_next = {chunk_size, pos_inc[31:0]};
                        end
                        remaining_next = chunk_size;
                        body_idx_next  = '0;
                        phase_next     = rwhp_pkg::PH_BODY;
                        finish         = (chunk_size == 32'd0);
                    end
                end
                rwhp_pkg::PH_BODY:
                begin
                    // A format chunk always has at least 16 body bytes, so every
                    // kept byte is written before the chunk can be committed.
                    if (kind_reg == rwhp_pkg::KIND_FMT && !body_idx_reg[4])
                    begin
                        pending_fmt_next[{body_idx_reg[3:0], 3'b000} +: 8] = stream.file_byte;
                    end
                    if (!body_idx_reg[4])
                    begin
                        body_idx_next = body_idx_reg + 5'd1;
                    end
                    remaining_next = remaining_reg - 32'd1;
                    finish         = (remaining_reg == 32'd1);
                end
                rwhp_pkg::PH_DEAD:
                begin
                end
                default:
                begin
                end
            endcase

            if (finish)
            begin
                if (kind_next == rwhp_pkg::KIND_FMT)
                begin
                    fmt_next       = pending_fmt_next;
                    fmt_found_next = 1'b1;
                end
                else if (kind_next == rwhp_pkg::KIND_DATA)
                begin
                    span_next       = pending_span_next;
                    data_found_next = 1'b1;
                end
                kind_next      = rwhp_pkg::KIND_OTHER;
                hdr_count_next = '0;
                phase_next     = rwhp_pkg::PH_HDR;
            end

            if (pos_reg != '1)
            begin
                pos_next = pos_inc[POSITION_BITS-1:0];
            end

            if (stream.is_last)
            begin
                if (pos_reg < POSITION_BITS'(rwhp_pkg::SIG_LAST))
                begin
                    res_next.status = rwhp_pkg::ST_SHORT;
                end
                else if (!tags_ok_next)
                begin
                    res_next.status = rwhp_pkg::ST_BAD_TAGS;
                end
                else if (!fmt_found_next)
                begin
                    res_next.status = rwhp_pkg::ST_NO_FORMAT;
                end
                else if (!data_found_next)
                begin
                    res_next.status = rwhp_pkg::ST_NO_DATA;
                end
                else
                begin
                    res_next.status = rwhp_pkg::ST_OK;
                end
                res_next.format_tag     = fmt_next[15:0];
                res_next.channel_count  = fmt_next[31:16];
                res_next.sample_rate    = fmt_next[63:32];
                res_next.byte_rate      = fmt_next[95:64];
                res_next.frame_align    = fmt_next[111:96];
                res_next.sample_bits    = fmt_next[127:112];
                res_next.payload_offset = span_next[31:0];
                res_next.payload_length = span_next[63:32];
                res_valid_next          = 1'b1;

                // The next byte is offset zero of a new file.
                pos_next          = '0;
                phase_next        = rwhp_pkg::PH_SIG;
                tags_ok_next      = 1'b1;
                sig_next          = '0;
                hdr_count_next    = '0;
                remaining_next    = '0;
                body_idx_next     = '0;
                kind_next         = rwhp_pkg::KIND_OTHER;
                pending_fmt_next  = '0;
                fmt_next          = '0;
                fmt_found_next    = 1'b0;
                pending_span_next = '0;
                span_next         = '0;
                data_found_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            phase_reg        <= rwhp_pkg::PH_SIG;
            tags_ok_reg      <= 1'b1;
            sig_reg          <= '0;
            hdr_reg          <= '0;
            hdr_count_reg    <= '0;
            remaining_reg    <= '0;
            body_idx_reg     <= '0;
            kind_reg         <= rwhp_pkg::KIND_OTHER;
            pending_fmt_reg  <= '0;
            fmt_reg          <= '0;
            fmt_found_reg    <= 1'b0;
            pending_span_reg <= '0;
            span_reg         <= '0;
            data_found_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            pos_reg          <= pos_next;
            phase_reg        <= phase_next;
            tags_ok_reg      <= tags_ok_next;
            sig_reg          <= sig_next;
            hdr_reg          <= (accept && stream.is_last) ? 64'd0 : hdr_next;
            hdr_count_reg    <= hdr_count_next;
            remaining_reg    <= remaining_next;
            body_idx_reg     <= body_idx_next;
            kind_reg         <= kind_next;
            pending_fmt_reg  <= pending_fmt_next;
            fmt_reg          <= fmt_next;
            fmt_found_reg    <= fmt_found_next;
            pending_span_reg <= pending_span_next;
            span_reg         <= span_next;
            data_found_reg   <= data_found_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign report.valid          = res_valid_reg;
    assign report.status         = res_reg.status;
    assign report.format_tag     = res_reg.format_tag;
    assign report.channel_count  = res_reg.channel_count;
    assign report.sample_rate    = res_reg.sample_rate;
    assign report.byte_rate      = res_reg.byte_rate;
    assign report.frame_align    = res_reg.frame_align;
    assign report.sample_bits    = res_reg.sample_bits;
    assign report.payload_offset = res_reg.payload_offset;
    assign report.payload_length = res_reg.payload_length;

`ifndef SYNTHESIS
    // A report only appears after the final byte of a file was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(accept && stream.is_last))
        else $error("report raised without a final byte");

    // An untaken report must hold the byte stream off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !report.ready) |-> !stream.ready)
        else $error("byte stream accepted while report stalled");

    // The final byte returns the parser to the start of a new file.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stream.is_last) |=> (pos_reg == '0 && phase_reg == rwhp_pkg::PH_SIG
                                        && !fmt_found_reg && !data_found_reg))
        else $error("parser state not cleared after final byte");

    // A chunk body in progress always has bytes left to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rwhp_pkg::PH_BODY) |-> (remaining_reg != 32'd0))
        else $error("body phase with no bytes remaining");
`endif

endmodule

`default_nettype wire
